// File: hdl/cache_tag_lookup_replace_top_macros.svh
// Assertion macros for the cache tag lookup block.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef CACHE_TAG_LOOKUP_REPLACE_TOP_MACROS_SVH
`define CACHE_TAG_LOOKUP_REPLACE_TOP_MACROS_SVH

// same-cycle implication
`define CTLR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ctlr check failed");

// next-cycle implication
`define CTLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ctlr check failed");

`endif

// File: hdl/ctlr_pkg.sv
// Shared types, constants and functions for the cache tag lookup block.
// No dependencies.
package ctlr_pkg;

    localparam int LINES_DEF     = 128;
    localparam int ADDR_BITS_DEF = 32;
    localparam int ADDR_W        = 32;
    localparam int LINE_OUT_W    = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int OFF_W         = 3;
    localparam int LIU_W         = 8;
    localparam int IDX_W         = 7;
    localparam int LFSR_W        = 16;
    localparam int CNT_OUT_W     = 32;
    localparam int OUT_DATA_W    = 72;

    localparam logic [LFSR_W-1:0]    LFSR_SEED = 16'hACE1;
    localparam logic [CNT_OUT_W-1:0] SAT_MAX   = {CNT_OUT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORG    = 3'd0,
        CFG_RMODE  = 3'd1,
        CFG_OFFSET = 3'd2,
        CFG_INDEX  = 3'd3,
        CFG_LINES  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic start;
        logic dm_line;
        logic mod_rnd;
        logic mod_take;
        logic rd;
        logic dm_cmp;
        logic fa_cmp;
        logic vict;
        logic wr;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic org;
        logic rmode;
        logic mod_done;
        logic fa_match;
        logic scan_last;
        logic inv_found;
        logic out_free;
    } t_stat;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
        logic b;
        b = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {b, l[LFSR_W-1:1]};
    endfunction

endpackage

// File: hdl/ctlr_mod.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on ctlr_pkg.
module ctlr_mod #(
    parameter int LINES = ctlr_pkg::LINES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [ctlr_pkg::LFSR_W-1:0]        i_dividend,
    input  logic [$clog2(LINES+1)-1:0]         i_divisor,
    output logic                               o_done,
    output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] o_rem
);
    import ctlr_pkg::*;

    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CNT_W  = $clog2(LINES + 1);
    localparam int STEP_W = $clog2(LFSR_W);
    localparam logic [STEP_W-1:0] LAST = STEP_W'(LFSR_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [LFSR_W-1:0] r_num;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_num[LFSR_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[LFSR_W-2:0], 1'b0};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = LINE_W'(r_rem);

endmodule

// File: hdl/ctlr_dp.sv
// Datapath: config registers, tag memory, valid bits, victim logic, counts
// and output register. Depends on ctlr_pkg and ctlr_mod.
module ctlr_dp #(
    parameter int LINES     = ctlr_pkg::LINES_DEF,
    parameter int ADDR_BITS = ctlr_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ctlr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ctlr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [ctlr_pkg::ADDR_W-1:0]       i_addr,
    input  ctlr_pkg::t_cmd                    i_cmd,
    output ctlr_pkg::t_stat                   o_stat,
    input  logic                              i_m_axis_tready,
    output logic                              o_m_axis_tvalid,
    output logic                              o_m_axis_tuser,
    output logic [ctlr_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import ctlr_pkg::*;

    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CNT_W  = $clog2(LINES + 1);
    localparam logic [63:0] MASK64 = (ADDR_BITS >= 64) ? {64{1'b1}} :
                                     ((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] ADDR_MASK = MASK64[ADDR_W-1:0];

    // config
    logic             r_org;
    logic             r_rmode;
    logic [OFF_W-1:0] r_off;
    logic [OFF_W-1:0] r_ib;
    logic [LIU_W-1:0] r_liu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org   <= 1'b0;
            r_rmode <= 1'b0;
            r_off   <= 3'd4;
            r_ib    <= 3'd1;
            r_liu   <= 8'd2;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORG:    r_org   <= i_cfg_data[0];
                CFG_RMODE:  r_rmode <= i_cfg_data[0];
                CFG_OFFSET: r_off   <= i_cfg_data[OFF_W-1:0];
                CFG_INDEX:  r_ib    <= i_cfg_data[OFF_W-1:0];
                CFG_LINES:  r_liu   <= i_cfg_data[LIU_W-1:0];
                default: ;
            endcase
        end
    end

    // lines in use, clamped to 1..LINES
    logic [CNT_W-1:0] n_act;
    always_comb begin
        if (r_liu == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(r_liu) > 32'(LINES)) begin
            n_act = CNT_W'(LINES);
        end else begin
            n_act = CNT_W'(r_liu);
        end
    end

    // address decode
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] addr_m;
    logic [ADDR_W-1:0] tag_fa;
    logic [ADDR_W-1:0] tag_dm;
    logic [ADDR_W-1:0] idx_full;
    logic [IDX_W-1:0]  idx_mask;
    logic [IDX_W-1:0]  idx;
    logic [LINE_W-1:0] idx_wrap;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_addr;
        end
    end

    assign addr_m   = r_addr & ADDR_MASK;
    assign tag_fa   = addr_m >> r_off;
    assign tag_dm   = addr_m >> ({1'b0, r_off} + {1'b0, r_ib});
    assign idx_full = addr_m >> r_off;
    assign idx_mask = IDX_W'((8'd1 << r_ib) - 8'd1);
    assign idx      = idx_full[IDX_W-1:0] & idx_mask;

    // index modulo LINES as a constant lookup table
    always_comb begin
        idx_wrap = '0;
        for (int i = 0; i < (1 << IDX_W); i++) begin
            if (idx == IDX_W'(i)) begin
                idx_wrap = LINE_W'(i % LINES);
            end
        end
    end

    // working registers
    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] r_scan;
    logic [LINE_W-1:0] r_first_inv;
    logic              r_inv_found;
    logic              r_hit;
    logic [LINE_W-1:0] r_fifo;
    logic [LFSR_W-1:0] r_lfsr;
    logic [LFSR_W-1:0] n_lfsr;

    // tag memory and valid bits
    logic [ADDR_W-1:0] mem [LINES];
    logic              r_valid [LINES];
    logic [ADDR_W-1:0] r_rd_tag;
    logic              r_rd_valid;
    logic [LINE_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wd;
    logic              dm_match;
    logic              fa_match;

    assign rd_addr  = r_org ? r_scan : r_line;
    assign dm_match = r_rd_valid && (r_rd_tag == tag_dm);
    assign fa_match = r_rd_valid && (r_rd_tag == tag_fa);
    assign mem_we   = (i_cmd.dm_cmp && !dm_match) || i_cmd.wr;
    assign mem_wd   = r_org ? tag_fa : tag_dm;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_line] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rd_tag <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (mem_we) begin
            r_valid[r_line] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    // remainder unit for the random victim
    logic [LFSR_W-1:0] mod_num;
    logic [CNT_W-1:0]  mod_den;
    logic              mod_done;
    logic [LINE_W-1:0] mod_rem;

    assign n_lfsr  = lfsr_next(r_lfsr);
    assign mod_num = n_lfsr;
    assign mod_den = n_act;

    ctlr_mod #(.LINES(LINES)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_rnd),
        .i_dividend (mod_num),
        .i_divisor  (mod_den),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // fifo victim
    logic [LINE_W-1:0] fifo_v;
    logic [LINE_W-1:0] n_fifo;
    assign fifo_v = (CNT_W'(r_fifo) < n_act) ? r_fifo : '0;
    assign n_fifo = ((CNT_W'(fifo_v) + 1'b1) == n_act) ? '0 : fifo_v + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo <= '0;
            r_lfsr <= LFSR_SEED;
        end else begin
            if (i_cmd.vict && !r_inv_found) begin
                r_fifo <= n_fifo;
            end
            if (i_cmd.mod_rnd) begin
                r_lfsr <= n_lfsr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scan      <= '0;
            r_inv_found <= 1'b0;
            r_hit       <= 1'b0;
        end
        if (i_cmd.dm_line) begin
            r_line <= idx_wrap;
        end
        if (i_cmd.mod_take) begin
            r_line <= mod_rem;
        end
        if (i_cmd.dm_cmp) begin
            r_hit <= dm_match;
        end
        if (i_cmd.fa_cmp) begin
            if (fa_match) begin
                r_hit  <= 1'b1;
                r_line <= r_scan;
            end else begin
                if (!r_rd_valid && !r_inv_found) begin
                    r_inv_found <= 1'b1;
                    r_first_inv <= r_scan;
                end
                r_scan <= r_scan + 1'b1;
            end
        end
        if (i_cmd.vict) begin
            r_line <= r_inv_found ? r_first_inv : fifo_v;
        end
    end

    // counts and output register
    logic [CNT_OUT_W-1:0] r_acc;
    logic [CNT_OUT_W-1:0] r_miss;
    logic [CNT_OUT_W-1:0] n_acc;
    logic [CNT_OUT_W-1:0] n_miss;
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [LINE_OUT_W-1:0] r_out_line;
    logic [CNT_OUT_W-1:0] r_out_acc;
    logic [CNT_OUT_W-1:0] r_out_miss;
    logic                 out_free;

    assign n_acc    = (r_acc == SAT_MAX) ? r_acc : r_acc + 1'b1;
    assign n_miss   = (r_hit || r_miss == SAT_MAX) ? r_miss : r_miss + 1'b1;
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.done) begin
                r_acc       <= n_acc;
                r_miss      <= n_miss;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_out_hit  <= r_hit;
            r_out_line <= LINE_OUT_W'(r_line);
            r_out_acc  <= n_acc;
            r_out_miss <= n_miss;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = {1'b0, r_out_miss, r_out_acc, r_out_line};

    assign o_stat.org       = r_org;
    assign o_stat.rmode     = r_rmode;
    assign o_stat.mod_done  = mod_done;
    assign o_stat.fa_match  = fa_match;
    assign o_stat.scan_last = (CNT_W'(r_scan) + 1'b1) == n_act;
    assign o_stat.inv_found = r_inv_found;
    assign o_stat.out_free  = out_free;

endmodule

// File: hdl/ctlr_ctrl.sv
// Controller state machine sequencing lookup, scan, victim choice and refill.
// Depends on ctlr_pkg.
module ctlr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  ctlr_pkg::t_stat i_stat,
    output ctlr_pkg::t_cmd  o_cmd
);
    import ctlr_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_START  = 9'b000000010,
        ST_MOD    = 9'b000000100,
        ST_DM_RD  = 9'b000001000,
        ST_DM_CMP = 9'b000010000,
        ST_FA_RD  = 9'b000100000,
        ST_FA_CMP = 9'b001000000,
        ST_VICT   = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

    // refill write runs in the cycle after the victim is chosen, flagged by r_wr
    t_state r_state;
    t_state n_state;
    logic   r_wr;
    logic   n_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wr    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr    <= n_wr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wr    = 1'b0;
        o_cmd   = '0;
        o_s_axis_tready = 1'b0;
        if (r_wr) begin
            o_cmd.wr = 1'b1;
            n_state  = ST_DONE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    o_s_axis_tready = i_rst_n;
                    if (i_s_axis_tvalid && i_rst_n) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_START;
                    end
                end
                ST_START: begin
                    o_cmd.start = 1'b1;
                    if (i_stat.org) begin
                        n_state = ST_FA_RD;
                    end else begin
                        o_cmd.dm_line = 1'b1;
                        n_state       = ST_DM_RD;
                    end
                end
                ST_MOD: begin
                    if (i_stat.mod_done) begin
                        o_cmd.mod_take = 1'b1;
                        n_wr           = 1'b1;
                        n_state        = ST_DONE;
                    end
                end
                ST_DM_RD: begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_DM_CMP;
                end
                ST_DM_CMP: begin
                    o_cmd.dm_cmp = 1'b1;
                    n_state      = ST_DONE;
                end
                ST_FA_RD: begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_FA_CMP;
                end
                ST_FA_CMP: begin
                    o_cmd.fa_cmp = 1'b1;
                    if (i_stat.fa_match) begin
                        n_state = ST_DONE;
                    end else if (i_stat.scan_last) begin
                        n_state = ST_VICT;
                    end else begin
                        n_state = ST_FA_RD;
                    end
                end
                ST_VICT: begin
                    if (i_stat.inv_found || !i_stat.rmode) begin
                        o_cmd.vict = 1'b1;
                        n_wr       = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        o_cmd.mod_rnd = 1'b1;
                        n_state       = ST_MOD;
                    end
                end
                ST_DONE: begin
                    if (i_stat.out_free) begin
                        o_cmd.done = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/cache_tag_lookup_replace_top.sv
// Top level of the cache tag lookup and replacement block.
// Depends on ctlr_pkg, ctlr_ctrl and ctlr_dp.
//
// One address word in, one result word out. Lookups run one at a time under
// a controller FSM; the next address is accepted while the previous result
// still sits in the output register. Direct mapped: the line is read, then
// compared; an index not below LINES wraps through a constant table at no
// extra cost. Fully associative: the tag memory has one read port, so the
// scan reads and then compares one line at a time; a hit on line k ends the
// scan there, a miss scans all n lines in use (plus the LFSR remainder unit
// for a random victim). A result that is not taken stalls the next one.
// Valid bits are flops cleared by reset, so no clearing pass is needed.
// Results: tuser = hit; tdata as listed below.
module cache_tag_lookup_replace_top #(
    parameter int LINES     = ctlr_pkg::LINES_DEF,
    parameter int ADDR_BITS = ctlr_pkg::ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ctlr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ctlr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ctlr_pkg::ADDR_W-1:0]      i_s_axis_tdata,   // [31:0] address
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic                             o_m_axis_tuser,   // [0] hit
    // [6:0] line_touched, [38:7] access_count, [70:39] miss_count, [71] zero
    output logic [ctlr_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import ctlr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ctlr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    ctlr_dp #(
        .LINES     (LINES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_addr          (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// File: hdl/ctlr_chk.sv
// Port checker for the cache tag lookup block, bound to the top level.
// Depends on ctlr_pkg and the assertion macro header.
`include "cache_tag_lookup_replace_top_macros.svh"

module ctlr_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic                            o_m_axis_tuser,
    input logic [ctlr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    `CTLR_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `CTLR_ASSERT_NEXT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    // one word in flight: busy right after an accept
    `CTLR_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // a fresh result frees the input side at once
    `CTLR_ASSERT_NOW(a_ready_with_result, $rose(o_m_axis_tvalid), o_s_axis_tready)

endmodule

bind cache_tag_lookup_replace_top ctlr_chk u_chk (.*);
